>>> hw/rtl/pts_pkg.sv
// Package for the priority task scheduler with timeout drop.
// Holds the sizes, the task table entry type, the sequencer states and helpers.
// Used by the top level and by the port checker.
`default_nettype none

package pts_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = IDX_BITS + 1;
   localparam int TIME_BITS   = 16;
   localparam int WIN_BITS    = 8;
   localparam int LVL_BITS    = 3;
   localparam int NUM_LEVELS  = 6;
   localparam int SUM_BITS    = 32;

   localparam logic [WIN_BITS-1:0]  WINDOW_RESET = WIN_BITS'(20);
   localparam logic [LVL_BITS-1:0]  TOP_LEVEL    = LVL_BITS'(5);
   localparam logic [LVL_BITS-1:0]  RR_LEVEL     = LVL_BITS'(3);
   localparam logic [CNT_BITS-1:0]  RR_NONE      = '1;
   localparam logic [TIME_BITS-1:0] TIME_MAX     = '1;

   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_FIRST    = 2'd1;
   localparam logic [1:0] EV_CONT     = 2'd2;
   localparam logic [1:0] EV_DROPPED  = 2'd3;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef struct packed {
      logic [TIME_BITS-1:0] arrival;
      logic [LVL_BITS-1:0]  level;
      logic [TIME_BITS-1:0] burst;
      logic [TIME_BITS-1:0] remaining;
      logic [TIME_BITS:0]   deadline;
   } task_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RUN_RD,
      ST_RUN_WR,
      ST_CHECK,
      ST_EMIT
   } sched_state_type;

   function automatic logic [7:0] sat_inc8(input logic [7:0] v);
      sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/priority_task_scheduler_timeout_top.sv
// One request is worked on at a time (req_stall is high outside idle); a load and a tick each
// scan the task table through the single read port of the task memory.
// Reset (synchronous, active high) clears counters, time, active and started bits;
// the task memory itself is not cleared.
// Top level of the scheduler; depends on pts_pkg.
`default_nettype none

module priority_task_scheduler_timeout_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_action,
   input  wire logic [15:0]         req_arrival_time,
   input  wire logic [2:0]          req_task_priority,
   input  wire logic [15:0]         req_burst_time,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [15:0]              rsp_sim_time,
   output logic                     rsp_chosen_valid,
   output logic [6:0]               rsp_chosen_index,
   output logic [1:0]               rsp_run_event,
   output logic                     rsp_task_finished,
   output logic [7:0]               rsp_dropped_now,
   output logic [7:0]               rsp_completed_total,
   output logic [7:0]               rsp_dropped_total,
   output logic [31:0]              rsp_turnaround_sum,
   output logic signed [31:0]       rsp_waiting_sum,
   output logic                     rsp_all_done,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [7:0]          csr_timeout_window
);

   localparam int D  = pts_pkg::TABLE_DEPTH;
   localparam int IB = pts_pkg::IDX_BITS;
   localparam int CB = pts_pkg::CNT_BITS;
   localparam int TB = pts_pkg::TIME_BITS;
   localparam int NL = pts_pkg::NUM_LEVELS;

   pts_pkg::sched_state_type state_ff, state_in;

   pts_pkg::task_entry_type mem [D];
   pts_pkg::task_entry_type rd_data_ff;
   pts_pkg::task_entry_type wr_data;
   logic                    mem_we;
   logic [IB-1:0]           wr_addr;
   logic [IB-1:0]           rd_addr;

   logic [7:0]        window_ff, window_in;
   logic [CB-1:0]     total_ff, total_in;
   logic [TB-1:0]     now_ff, now_in;
   logic [CB-1:0]     rr_last_ff, rr_last_in;
   logic [7:0]        done_cnt_ff, done_cnt_in;
   logic [7:0]        drop_cnt_ff, drop_cnt_in;
   logic [31:0]       turn_acc_ff, turn_acc_in;
   logic signed [31:0] wait_acc_ff, wait_acc_in;
   logic [D-1:0]      active_ff, active_in;
   logic [D-1:0]      started_ff, started_in;

   logic [CB-1:0]     scan_ff, scan_in;
   logic              pipe_vld_ff, pipe_vld_in;
   logic [IB-1:0]     pipe_idx_ff, pipe_idx_in;
   logic [NL-1:0]     found_ff, found_in;
   logic [IB-1:0]     first_ff [NL];
   logic [IB-1:0]     first_in [NL];
   logic              rr_found_ff, rr_found_in;
   logic [IB-1:0]     rr_idx_ff, rr_idx_in;

   logic              chosen_vld_ff, chosen_vld_in;
   logic [IB-1:0]     chosen_idx_ff, chosen_idx_in;
   logic [1:0]        event_ff, event_in;
   logic              finished_ff, finished_in;
   logic [7:0]        dropped_ff, dropped_in;
   logic              done_ok_ff, done_ok_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_time_ff, rsp_time_in;
   logic              rsp_cv_ff, rsp_cv_in;
   logic [6:0]        rsp_ci_ff, rsp_ci_in;
   logic [1:0]        rsp_ev_ff, rsp_ev_in;
   logic              rsp_fin_ff, rsp_fin_in;
   logic [7:0]        rsp_dn_ff, rsp_dn_in;
   logic [7:0]        rsp_ct_ff, rsp_ct_in;
   logic [7:0]        rsp_dt_ff, rsp_dt_in;
   logic [31:0]       rsp_ts_ff, rsp_ts_in;
   logic signed [31:0] rsp_ws_ff, rsp_ws_in;
   logic              rsp_ad_ff, rsp_ad_in;

   logic              req_take;
   logic              scan_issue;
   logic              scan_end;
   logic              out_free;
   logic              hit, act_post, live, drop_hit;
   logic [CB-1:0]     rr_start;
   logic              pick_vld, pick_rr;
   logic [IB-1:0]     pick_idx;
   logic [TB-1:0]     rem_new;
   logic [TB-1:0]     turn;
   logic signed [TB+1:0] wait_v;
   logic [32:0]       turn_sum;
   logic signed [33:0] wait_sum;

   assign req_stall = (state_ff != pts_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign scan_issue = ((state_ff == pts_pkg::ST_SCAN) || (state_ff == pts_pkg::ST_CHECK))
                       && (scan_ff < total_ff);
   assign scan_end   = (scan_ff >= total_ff) && !pipe_vld_ff;

   assign rd_addr = (state_ff == pts_pkg::ST_RUN_RD) ? chosen_idx_ff : scan_ff[IB-1:0];

   // per-entry evaluation of the scanned slot
   assign hit      = (rd_data_ff.arrival == now_ff);
   assign act_post = active_ff[pipe_idx_ff] || hit;
   assign live     = act_post && (rd_data_ff.remaining != '0);
   assign drop_hit = live && ({1'b0, now_ff} >= rd_data_ff.deadline);

   assign rr_start = (rr_last_ff >= total_ff) ? '0 : rr_last_ff + CB'(1);

   always_comb begin
      pick_vld = 1'b0;
      pick_rr  = 1'b0;
      pick_idx = '0;
      if (found_ff[0]) begin
         pick_vld = 1'b1; pick_idx = first_ff[0];
      end else if (found_ff[1]) begin
         pick_vld = 1'b1; pick_idx = first_ff[1];
      end else if (found_ff[2]) begin
         pick_vld = 1'b1; pick_idx = first_ff[2];
      end else if (rr_found_ff) begin
         pick_vld = 1'b1; pick_rr = 1'b1; pick_idx = rr_idx_ff;
      end else if (found_ff[3]) begin
         pick_vld = 1'b1; pick_rr = 1'b1; pick_idx = first_ff[3];
      end else if (found_ff[4]) begin
         pick_vld = 1'b1; pick_idx = first_ff[4];
      end else if (found_ff[5]) begin
         pick_vld = 1'b1; pick_idx = first_ff[5];
      end
   end

   // finishing arithmetic for the chosen task
   assign rem_new  = rd_data_ff.remaining - TB'(1);
   assign turn     = (now_ff >= rd_data_ff.arrival) ? now_ff - rd_data_ff.arrival : '0;
   assign wait_v   = $signed({2'b00, turn}) - $signed({2'b00, rd_data_ff.burst});
   assign turn_sum = {1'b0, turn_acc_ff} + 33'(turn);
   assign wait_sum = 34'(wait_acc_ff) + 34'(wait_v);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pts_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = (req_action == pts_pkg::ACT_TICK) ? pts_pkg::ST_SCAN
                                                            : pts_pkg::ST_CHECK;
            end
         end
         pts_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = pick_vld ? pts_pkg::ST_RUN_RD : pts_pkg::ST_CHECK;
            end
         end
         pts_pkg::ST_RUN_RD: state_in = pts_pkg::ST_RUN_WR;
         pts_pkg::ST_RUN_WR: state_in = pts_pkg::ST_CHECK;
         pts_pkg::ST_CHECK: begin
            if (scan_end) begin
               state_in = pts_pkg::ST_EMIT;
            end
         end
         pts_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = pts_pkg::ST_IDLE;
            end
         end
         default: state_in = pts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      window_in   = window_ff;
      total_in    = total_ff;
      now_in      = now_ff;
      rr_last_in  = rr_last_ff;
      done_cnt_in = done_cnt_ff;
      drop_cnt_in = drop_cnt_ff;
      turn_acc_in = turn_acc_ff;
      wait_acc_in = wait_acc_ff;
      active_in   = active_ff;
      started_in  = started_ff;
      scan_in     = scan_ff;
      pipe_vld_in = scan_issue;
      pipe_idx_in = scan_ff[IB-1:0];
      found_in    = found_ff;
      first_in    = first_ff;
      rr_found_in = rr_found_ff;
      rr_idx_in   = rr_idx_ff;
      chosen_vld_in = chosen_vld_ff;
      chosen_idx_in = chosen_idx_ff;
      event_in    = event_ff;
      finished_in = finished_ff;
      dropped_in  = dropped_ff;
      done_ok_in  = done_ok_ff;
      mem_we      = 1'b0;
      wr_addr     = total_ff[IB-1:0];
      wr_data     = rd_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_time_in = rsp_time_ff;
      rsp_cv_in   = rsp_cv_ff;
      rsp_ci_in   = rsp_ci_ff;
      rsp_ev_in   = rsp_ev_ff;
      rsp_fin_in  = rsp_fin_ff;
      rsp_dn_in   = rsp_dn_ff;
      rsp_ct_in   = rsp_ct_ff;
      rsp_dt_in   = rsp_dt_ff;
      rsp_ts_in   = rsp_ts_ff;
      rsp_ws_in   = rsp_ws_ff;
      rsp_ad_in   = rsp_ad_ff;

      if (csr_valid && csr_ready) begin
         window_in = csr_timeout_window;
      end
      if (scan_issue) begin
         scan_in = scan_ff + CB'(1);
      end

      case (state_ff)
         pts_pkg::ST_IDLE: begin
            scan_in       = '0;
            found_in      = '0;
            rr_found_in   = 1'b0;
            chosen_vld_in = 1'b0;
            chosen_idx_in = '0;
            event_in      = pts_pkg::EV_NONE;
            finished_in   = 1'b0;
            dropped_in    = '0;
            done_ok_in    = 1'b1;
            if (req_take && (req_action == pts_pkg::ACT_LOAD) && (total_ff < CB'(D))) begin
               mem_we             = 1'b1;
               wr_data.arrival    = req_arrival_time;
               wr_data.level      = req_task_priority;
               wr_data.burst      = req_burst_time;
               wr_data.remaining  = req_burst_time;
               wr_data.deadline   = {1'b0, req_arrival_time} + (TB+1)'(window_ff);
               active_in[total_ff[IB-1:0]]  = 1'b0;
               started_in[total_ff[IB-1:0]] = 1'b0;
               total_in = total_ff + CB'(1);
            end
         end
         pts_pkg::ST_SCAN: begin
            if (pipe_vld_ff) begin
               active_in[pipe_idx_ff] = act_post && !drop_hit;
               if (hit) begin
                  started_in[pipe_idx_ff] = 1'b0;
               end
               if (drop_hit) begin
                  drop_cnt_in = pts_pkg::sat_inc8(drop_cnt_ff);
                  dropped_in  = pts_pkg::sat_inc8(dropped_ff);
               end
               if (live && (rd_data_ff.level < pts_pkg::LVL_BITS'(NL))) begin
                  if (!found_ff[rd_data_ff.level]) begin
                     found_in[rd_data_ff.level] = 1'b1;
                     first_in[rd_data_ff.level] = pipe_idx_ff;
                  end
                  if ((rd_data_ff.level == pts_pkg::RR_LEVEL) && !rr_found_ff &&
                      ({1'b0, pipe_idx_ff} >= rr_start)) begin
                     rr_found_in = 1'b1;
                     rr_idx_in   = pipe_idx_ff;
                  end
               end
            end
            if (scan_end) begin
               scan_in       = '0;
               chosen_vld_in = pick_vld;
               chosen_idx_in = pick_vld ? pick_idx : '0;
               if (pick_rr) begin
                  rr_last_in = {1'b0, pick_idx};
               end
               if (now_ff != pts_pkg::TIME_MAX) begin
                  now_in = now_ff + TB'(1);
               end
            end
         end
         pts_pkg::ST_RUN_WR: begin
            if (!active_ff[chosen_idx_ff]) begin
               event_in = pts_pkg::EV_DROPPED;
            end else begin
               event_in = started_ff[chosen_idx_ff] ? pts_pkg::EV_CONT : pts_pkg::EV_FIRST;
               started_in[chosen_idx_ff] = 1'b1;
               mem_we            = 1'b1;
               wr_addr           = chosen_idx_ff;
               wr_data.remaining = rem_new;
               if (rem_new == '0) begin
                  finished_in = 1'b1;
                  done_cnt_in = pts_pkg::sat_inc8(done_cnt_ff);
                  turn_acc_in = turn_sum[32] ? 32'hFFFF_FFFF : turn_sum[31:0];
                  if (wait_sum > 34'sh0_7FFF_FFFF) begin
                     wait_acc_in = 32'sh7FFF_FFFF;
                  end else if (wait_sum < -34'sh0_8000_0000) begin
                     wait_acc_in = -32'sh8000_0000;
                  end else begin
                     wait_acc_in = wait_sum[31:0];
                  end
                  active_in[chosen_idx_ff] = 1'b0;
               end else begin
                  wr_data.deadline = {1'b0, now_ff} + (TB+1)'(window_ff);
                  if ((rd_data_ff.level != '0) && (rd_data_ff.level < pts_pkg::TOP_LEVEL)) begin
                     wr_data.level = rd_data_ff.level + pts_pkg::LVL_BITS'(1);
                  end
               end
            end
         end
         pts_pkg::ST_CHECK: begin
            if (pipe_vld_ff) begin
               if ((rd_data_ff.arrival > now_ff) ||
                   (active_ff[pipe_idx_ff] && (rd_data_ff.remaining != '0))) begin
                  done_ok_in = 1'b0;
               end
            end
            if (scan_end) begin
               scan_in = '0;
            end
         end
         pts_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = now_ff;
               rsp_cv_in    = chosen_vld_ff;
               rsp_ci_in    = chosen_idx_ff;
               rsp_ev_in    = event_ff;
               rsp_fin_in   = finished_ff;
               rsp_dn_in    = dropped_ff;
               rsp_ct_in    = done_cnt_ff;
               rsp_dt_in    = drop_cnt_ff;
               rsp_ts_in    = turn_acc_ff;
               rsp_ws_in    = wait_acc_ff;
               rsp_ad_in    = done_ok_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pts_pkg::ST_IDLE;
         window_ff     <= pts_pkg::WINDOW_RESET;
         total_ff      <= '0;
         now_ff        <= '0;
         rr_last_ff    <= pts_pkg::RR_NONE;
         done_cnt_ff   <= '0;
         drop_cnt_ff   <= '0;
         turn_acc_ff   <= '0;
         wait_acc_ff   <= '0;
         active_ff     <= '0;
         started_ff    <= '0;
         scan_ff       <= '0;
         pipe_vld_ff   <= 1'b0;
         found_ff      <= '0;
         rr_found_ff   <= 1'b0;
         chosen_vld_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_ff     <= window_in;
         total_ff      <= total_in;
         now_ff        <= now_in;
         rr_last_ff    <= rr_last_in;
         done_cnt_ff   <= done_cnt_in;
         drop_cnt_ff   <= drop_cnt_in;
         turn_acc_ff   <= turn_acc_in;
         wait_acc_ff   <= wait_acc_in;
         active_ff     <= active_in;
         started_ff    <= started_in;
         scan_ff       <= scan_in;
         pipe_vld_ff   <= pipe_vld_in;
         found_ff      <= found_in;
         rr_found_ff   <= rr_found_in;
         chosen_vld_ff <= chosen_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_idx_ff   <= pipe_idx_in;
      first_ff      <= first_in;
      rr_idx_ff     <= rr_idx_in;
      chosen_idx_ff <= chosen_idx_in;
      event_ff      <= event_in;
      finished_ff   <= finished_in;
      dropped_ff    <= dropped_in;
      done_ok_ff    <= done_ok_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_cv_ff     <= rsp_cv_in;
      rsp_ci_ff     <= rsp_ci_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_dn_ff     <= rsp_dn_in;
      rsp_ct_ff     <= rsp_ct_in;
      rsp_dt_ff     <= rsp_dt_in;
      rsp_ts_ff     <= rsp_ts_in;
      rsp_ws_ff     <= rsp_ws_in;
      rsp_ad_ff     <= rsp_ad_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sim_time        = rsp_time_ff;
   assign rsp_chosen_valid    = rsp_cv_ff;
   assign rsp_chosen_index    = rsp_ci_ff;
   assign rsp_run_event       = rsp_ev_ff;
   assign rsp_task_finished   = rsp_fin_ff;
   assign rsp_dropped_now     = rsp_dn_ff;
   assign rsp_completed_total = rsp_ct_ff;
   assign rsp_dropped_total   = rsp_dt_ff;
   assign rsp_turnaround_sum  = rsp_ts_ff;
   assign rsp_waiting_sum     = rsp_ws_ff;
   assign rsp_all_done        = rsp_ad_ff;

endmodule

`default_nettype wire

>>> hw/rtl/pts_checker.sv
// Port checker for the scheduler top level, attached by bind.
// Depends on pts_pkg for the run event codes.
`default_nettype none

module pts_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_sim_time,
   input wire logic        rsp_chosen_valid,
   input wire logic [6:0]  rsp_chosen_index,
   input wire logic [1:0]  rsp_run_event,
   input wire logic        rsp_task_finished
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sim_time))
      else $error("stalled response changed");

   a_no_pick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_chosen_valid |->
      rsp_chosen_index == 7'd0 && rsp_run_event == pts_pkg::EV_NONE)
      else $error("event without a chosen task");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_task_finished |->
      rsp_run_event == pts_pkg::EV_FIRST || rsp_run_event == pts_pkg::EV_CONT)
      else $error("finish without a run");

endmodule

bind priority_task_scheduler_timeout_top pts_port_checker u_pts_port_checker (.*);

`default_nettype wire
